// File: rtl/core/pdgc_pkg.sv
// Shared constants, types and helpers for the PD gravity compensation torque core.
// Depends on nothing; the core refers to it by scoped names.
package pdgc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_KP0   = 3'd0;
    localparam logic [2:0] REG_KP1   = 3'd1;
    localparam logic [2:0] REG_KP2   = 3'd2;
    localparam logic [2:0] REG_KV0   = 3'd3;
    localparam logic [2:0] REG_KV1   = 3'd4;
    localparam logic [2:0] REG_KV2   = 3'd5;
    localparam logic [2:0] REG_GRAV  = 3'd6;

    // Pipeline depth: register stages from input capture to output register
    localparam int NUM_STG = 16;

    // Angles in Q4.12
    localparam logic signed [16:0] TWO_PI  = 17'sd25736;
    localparam logic signed [16:0] PI      = 17'sd12868;
    localparam logic signed [16:0] HALF_PI = 17'sd6434;

    // Gravity coefficients, Q12 newton metres
    localparam logic signed [40:0] COEF_SHOULDER = 41'sd40960;
    localparam logic signed [40:0] COEF_ELBOW    = 41'sd20480;
    localparam logic signed [40:0] COEF_WRIST    = 41'sd4096;

    // Series term one in Q16
    localparam logic [16:0] T_ONE = 17'd65536;

    // Reciprocal constants: floor(v/d) = (v*ceil(2^k/d)) >> k for the operand widths used
    localparam int DIV72_SH = 25;
    localparam int DIV42_SH = 25;
    localparam int DIV20_SH = 24;
    localparam int DIV6_SH  = 22;
    localparam logic [19:0] DIV72_MUL = 20'((2**DIV72_SH + 71) / 72);
    localparam logic [19:0] DIV42_MUL = 20'((2**DIV42_SH + 41) / 42);
    localparam logic [19:0] DIV20_MUL = 20'((2**DIV20_SH + 19) / 20);
    localparam logic [19:0] DIV6_MUL  = 20'((2**DIV6_SH + 5) / 6);

    localparam logic signed [41:0] TAU_MAX = 42'sd8388607;
    localparam logic signed [41:0] TAU_MIN = -42'sd8388608;

    typedef logic signed [16:0] t_ang;

    // Reduce an angle sum into [-pi, pi)
    function automatic logic signed [14:0] reduce_ang(input t_ang a);
        t_ang r;
        if (a >= PI + TWO_PI) begin
            r = a - TWO_PI - TWO_PI;
        end else if (a >= PI) begin
            r = a - TWO_PI;
        end else if (a < -PI - TWO_PI) begin
            r = a + TWO_PI + TWO_PI;
        end else if (a < -PI) begin
            r = a + TWO_PI;
        end else begin
            r = a;
        end
        return r[14:0];
    endfunction

    // Fold the magnitude into [0, pi/2] and scale to Q16
    function automatic logic [16:0] fold_x(input logic signed [14:0] r);
        t_ang m;
        m = (r < 0) ? -t_ang'(r) : t_ang'(r);
        if (m > HALF_PI) begin
            m = PI - m;
        end
        return 17'(m) << 4;
    endfunction

endpackage

// File: rtl/core/pd_gravity_comp_torque_core.sv
// PD joint torque core with gravity compensation for a three-joint arm.
// Depends on pdgc_pkg (constants, angle reduction helpers).

// One beat in, one beat out: each input beat carries the measured angle, target
// angle and speed of three joints and yields one beat with three saturated Q12
// torques plus a clip flag in tuser. The datapath is a 16-stage pipeline (sine
// evaluation by a four-term series, one multiplier per stage) so a new beat is
// taken every cycle while the output is not stalled. Every stage has its own valid
// bit and advances whenever the stage after it is empty or moving, so bubbles
// collapse and a stall on m_tready holds data without loss. Gains and gravity_on
// come from the config channel, which is always ready; write it only while no
// beat is in flight.
module pd_gravity_comp_torque_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // angle_joint0..2 [44:0], target_joint0..2 [89:45], speed_joint0..2 [137:90], zero pad
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,
    // torque_joint0 [23:0], torque_joint1 [47:24], torque_joint2 [71:48]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,
    // clipped
    output logic         m_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    localparam int NS = pdgc_pkg::NUM_STG;

    // Configuration registers
    logic [15:0] r_kp [3];
    logic [15:0] r_kv [3];
    logic        r_grav;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 3; j++) begin
                r_kp[j] <= '0;
                r_kv[j] <= '0;
            end
            r_grav <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pdgc_pkg::REG_KP0:  r_kp[0] <= i_cfg_data;
                pdgc_pkg::REG_KP1:  r_kp[1] <= i_cfg_data;
                pdgc_pkg::REG_KP2:  r_kp[2] <= i_cfg_data;
                pdgc_pkg::REG_KV0:  r_kv[0] <= i_cfg_data;
                pdgc_pkg::REG_KV1:  r_kv[1] <= i_cfg_data;
                pdgc_pkg::REG_KV2:  r_kv[2] <= i_cfg_data;
                pdgc_pkg::REG_GRAV: r_grav  <= i_cfg_data[0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    // Stage valids and per-stage advance enables
    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !r_v[i] || en[i+1];
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= s_tvalid;
            end
            for (int i = 1; i < NS; i++) begin
                if (en[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    // Unpack input fields
    logic signed [14:0] in_ang [3];
    logic signed [14:0] in_tgt [3];
    logic signed [15:0] in_spd [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            in_ang[j] = s_tdata[15*j +: 15];
            in_tgt[j] = s_tdata[45 + 15*j +: 15];
            in_spd[j] = s_tdata[90 + 16*j +: 16];
        end
    end

    // Stage 0: angle sums and gain products
    pdgc_pkg::t_ang     r_ang [3];
    logic signed [32:0] r_pe  [3];
    logic signed [32:0] r_pv  [3];
    // Stage 1: reduced angles, PD sum (carried to stage 13)
    logic signed [14:0] r_red [3];
    logic signed [33:0] r_pd  [1:13][3];
    // Sign and folded Q16 argument (carried)
    logic               r_neg [2:11][3];
    logic [16:0]        r_x   [2:10][3];
    logic [17:0]        r_x2  [3:8][3];
    // Series evaluation
    logic [38:0]        r_q72 [3];
    logic [34:0]        r_p1  [3];
    logic [38:0]        r_q42 [3];
    logic [34:0]        r_p2  [3];
    logic [38:0]        r_q20 [3];
    logic [34:0]        r_p3  [3];
    logic [38:0]        r_q6  [3];
    logic [33:0]        r_s   [3];
    logic signed [16:0] r_sin [3];
    logic signed [40:0] r_ld  [3];
    logic signed [41:0] r_acc [3];
    logic [23:0]        r_tq  [3];
    logic               r_clip;

    // Series step terms
    logic [16:0] n_t1 [3];
    logic [16:0] n_t2 [3];
    logic [16:0] n_t3 [3];
    logic [16:0] n_t4 [3];
    logic [15:0] n_mag [3];
    logic signed [40:0] n_load [3];
    logic signed [41:0] n_rnd [3];
    logic [23:0] n_tq [3];
    logic [2:0]  n_sat;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_t1[j] = pdgc_pkg::T_ONE - 17'(r_q72[j] >> pdgc_pkg::DIV72_SH);
            n_t2[j] = pdgc_pkg::T_ONE - 17'(r_q42[j] >> pdgc_pkg::DIV42_SH);
            n_t3[j] = pdgc_pkg::T_ONE - 17'(r_q20[j] >> pdgc_pkg::DIV20_SH);
            n_t4[j] = pdgc_pkg::T_ONE - 17'(r_q6[j] >> pdgc_pkg::DIV6_SH);
            n_mag[j] = 16'((18'(r_s[j] >> 16) + 18'd2) >> 2);
        end
        // Wrist load feeds all joints, elbow joints 0-1, shoulder joint 0 only
        n_load[2] = r_ld[2];
        n_load[1] = r_ld[1] + r_ld[2];
        n_load[0] = r_ld[0] + r_ld[1] + r_ld[2];
        for (int j = 0; j < 3; j++) begin
            n_rnd[j] = (r_acc[j] + 42'sd8192) >>> 14;
            if (n_rnd[j] > pdgc_pkg::TAU_MAX) begin
                n_tq[j]  = pdgc_pkg::TAU_MAX[23:0];
                n_sat[j] = 1'b1;
            end else if (n_rnd[j] < pdgc_pkg::TAU_MIN) begin
                n_tq[j]  = pdgc_pkg::TAU_MIN[23:0];
                n_sat[j] = 1'b1;
            end else begin
                n_tq[j]  = n_rnd[j][23:0];
                n_sat[j] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // Stage 0: capture; lane 0 is cos(q1) as sin(q1 + pi/2)
        if (en[0]) begin
            r_ang[0] <= pdgc_pkg::t_ang'(in_ang[0]) + pdgc_pkg::HALF_PI;
            r_ang[1] <= pdgc_pkg::t_ang'(in_ang[0]) + pdgc_pkg::t_ang'(in_ang[1]);
            r_ang[2] <= pdgc_pkg::t_ang'(in_ang[0]) + pdgc_pkg::t_ang'(in_ang[1])
                      + pdgc_pkg::t_ang'(in_ang[2]);
            for (int j = 0; j < 3; j++) begin
                r_pe[j] <= $signed({1'b0, r_kp[j]})
                         * (16'(in_tgt[j]) - 16'(in_ang[j]));
                r_pv[j] <= $signed({1'b0, r_kv[j]}) * in_spd[j];
            end
        end
        for (int j = 0; j < 3; j++) begin
            // Stage 1: reduce modulo 2pi, form PD term
            if (en[1]) begin
                r_red[j]  <= pdgc_pkg::reduce_ang(r_ang[j]);
                r_pd[1][j] <= 34'(r_pe[j]) - 34'(r_pv[j]);
            end
            // Stage 2: fold to first quadrant
            if (en[2]) begin
                r_neg[2][j] <= r_red[j] < 0;
                r_x[2][j]   <= pdgc_pkg::fold_x(r_red[j]);
            end
            // Stage 3: square
            if (en[3]) begin
                r_x2[3][j] <= 18'((34'(r_x[2][j]) * 34'(r_x[2][j])) >> 16);
            end
            if (en[4]) begin
                r_q72[j] <= 39'(r_x2[3][j]) * 39'(pdgc_pkg::DIV72_MUL);
            end
            if (en[5]) begin
                r_p1[j] <= 35'(r_x2[4][j]) * 35'(n_t1[j]);
            end
            if (en[6]) begin
                r_q42[j] <= 39'(19'(r_p1[j] >> 16)) * 39'(pdgc_pkg::DIV42_MUL);
            end
            if (en[7]) begin
                r_p2[j] <= 35'(r_x2[6][j]) * 35'(n_t2[j]);
            end
            if (en[8]) begin
                r_q20[j] <= 39'(19'(r_p2[j] >> 16)) * 39'(pdgc_pkg::DIV20_MUL);
            end
            if (en[9]) begin
                r_p3[j] <= 35'(r_x2[8][j]) * 35'(n_t3[j]);
            end
            if (en[10]) begin
                r_q6[j] <= 39'(19'(r_p3[j] >> 16)) * 39'(pdgc_pkg::DIV6_MUL);
            end
            if (en[11]) begin
                r_s[j] <= 34'(r_x[10][j]) * 34'(n_t4[j]);
            end
            // Stage 12: round to Q2.14 and apply sign
            if (en[12]) begin
                r_sin[j] <= r_neg[11][j] ? -$signed({1'b0, n_mag[j]})
                                         : $signed({1'b0, n_mag[j]});
            end
            // Stage 14: PD scaled to Q26 plus gravity load
            if (en[14]) begin
                r_acc[j] <= (42'(r_pd[13][j]) <<< 6)
                          + (r_grav ? 42'(n_load[j]) : 42'sd0);
            end
            // Stage 15: round half up, saturate
            if (en[15]) begin
                r_tq[j] <= n_tq[j];
            end
        end
        // Stage 13: weight each sine by its arm coefficient
        if (en[13]) begin
            r_ld[0] <= 41'(r_sin[0]) * pdgc_pkg::COEF_SHOULDER;
            r_ld[1] <= 41'(r_sin[1]) * pdgc_pkg::COEF_ELBOW;
            r_ld[2] <= 41'(r_sin[2]) * pdgc_pkg::COEF_WRIST;
        end
        if (en[15]) begin
            r_clip <= |n_sat;
        end
        // Carry side data down the pipe
        for (int k = 2; k <= 13; k++) begin
            if (en[k]) begin
                r_pd[k] <= r_pd[k-1];
            end
        end
        for (int k = 3; k <= 11; k++) begin
            if (en[k]) begin
                r_neg[k] <= r_neg[k-1];
            end
        end
        for (int k = 3; k <= 10; k++) begin
            if (en[k]) begin
                r_x[k] <= r_x[k-1];
            end
        end
        for (int k = 4; k <= 8; k++) begin
            if (en[k]) begin
                r_x2[k] <= r_x2[k-1];
            end
        end
    end

    assign m_tdata = {r_tq[2], r_tq[1], r_tq[0]};
    assign m_tuser = r_clip;

endmodule

// File: tb/tb.sv
// Testbench for pd_gravity_comp_torque_core: PD torque with gravity load, three joints.
// Depends on pdgc_pkg for register indexes and pipeline depth; drives the reset, stream and config ports only.
`timescale 1ns / 100ps

class torque_scoreboard;
    bit [71:0] exp_torque_q[$];
    bit        exp_clip_q[$];
    int        mismatches;

    // Q2.14 sine of a Q4.12 angle by the folded four-term series
    static function longint sine_q14(longint a);
        longint r, m, x, x2, t, s;
        bit neg;
        r = a % 25736;
        if (r < 0) r += 25736;
        if (r >= 12868) r -= 25736;
        neg = r < 0;
        m = neg ? -r : r;
        if (m > 6434) m = 12868 - m;
        x = m * 16;
        x2 = (x * x) >>> 16;
        t = 65536 - x2 / 72;
        t = 65536 - ((x2 * t) >>> 16) / 42;
        t = 65536 - ((x2 * t) >>> 16) / 20;
        t = 65536 - ((x2 * t) >>> 16) / 6;
        s = (x * t) >>> 16;
        s = (s + 2) >>> 2;
        return neg ? -s : s;
    endfunction

    // Note an accepted tick and queue the torques it should produce
    function void note_tick(bit [143:0] d, bit [15:0] kp[3], bit [15:0] kv[3], bit grav);
        longint q[3], qd[3], dq[3], load[3];
        longint pd, acc, tau;
        bit [71:0] tq;
        bit clip;
        clip = 0;
        for (int j = 0; j < 3; j++) begin
            q[j]  = longint'($signed(d[15*j +: 15]));
            qd[j] = longint'($signed(d[45 + 15*j +: 15]));
            dq[j] = longint'($signed(d[90 + 16*j +: 16]));
        end
        load[2] = 4096 * sine_q14(q[0] + q[1] + q[2]);
        load[1] = 20480 * sine_q14(q[0] + q[1]) + load[2];
        load[0] = 40960 * sine_q14(q[0] + 6434) + load[1];
        for (int j = 0; j < 3; j++) begin
            pd = longint'(kp[j]) * (qd[j] - q[j]) - longint'(kv[j]) * dq[j];
            acc = pd * 64 + (grav ? load[j] : 0);
            tau = (acc + 8192) >>> 14;
            if (tau > 8388607) begin
                tau = 8388607;
                clip = 1;
            end else if (tau < -8388608) begin
                tau = -8388608;
                clip = 1;
            end
            tq[24*j +: 24] = tau[23:0];
        end
        exp_torque_q.push_back(tq);
        exp_clip_q.push_back(clip);
    endfunction

    function void check_result(bit [71:0] tq, bit clip);
        bit [71:0] e;
        bit ec;
        if (exp_torque_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", tq);
            return;
        end
        e = exp_torque_q.pop_front();
        ec = exp_clip_q.pop_front();
        for (int j = 0; j < 3; j++)
            if (e[24*j +: 24] !== tq[24*j +: 24]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("torque %0d: expected %0d got %0d", j,
                             $signed(e[24*j +: 24]), $signed(tq[24*j +: 24]));
            end
        if (ec !== clip) begin
            mismatches++;
            if (mismatches <= 10) $display("clipped: expected %0b got %0b", ec, clip);
        end
    endfunction
endclass

module tb;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;      // angles [44:0], targets [89:45], speeds [137:90]
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;      // torque_joint0, torque_joint1, torque_joint2
    logic         m_tuser;      // clipped
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [15:0]  i_cfg_data;

    pd_gravity_comp_torque_core dut (.*);

    torque_scoreboard sb = new();

    // Register shadow used for prediction
    bit [15:0] kp_shadow[3];
    bit [15:0] kv_shadow[3];
    bit        grav_shadow;

    bit calm;          // stretch with no idling on either side
    int stall_cycles;  // watchdog: cycles with no beat accepted
    bit timed_out;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random backpressure, check each accepted result beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 0;
        end else begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
            m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
        end
    end

    // Watchdog on handshake progress
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 2000 && !timed_out) begin
            timed_out = 1;
            $display("FAILURE");
            $finish;
        end
    end

    // Hold valid high across back-to-back writes; set_gains drops it at the end
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx <= pdgc_pkg::REG_KV2) begin
            if (idx < pdgc_pkg::REG_KV0) kp_shadow[idx] = val;
            else kv_shadow[idx - pdgc_pkg::REG_KV0] = val;
        end else if (idx == pdgc_pkg::REG_GRAV) grav_shadow = val[0];
    endtask

    task automatic set_gains(bit [15:0] kp, bit [15:0] kv, bit grav);
        write_reg(pdgc_pkg::REG_KP0, kp);
        write_reg(pdgc_pkg::REG_KP1, kp ^ 16'h0101);
        write_reg(pdgc_pkg::REG_KP2, kp >> 1);
        write_reg(pdgc_pkg::REG_KV0, kv);
        write_reg(pdgc_pkg::REG_KV1, kv ^ 16'h0202);
        write_reg(pdgc_pkg::REG_KV2, kv >> 2);
        write_reg(pdgc_pkg::REG_GRAV, {15'd0, grav});
        i_cfg_valid <= 0;
    endtask

    // Send one tick; idle first at random unless in a calm stretch.
    // Valid stays high after the beat so ticks can follow back to back.
    task automatic send_tick(bit [143:0] d);
        while (!calm && $urandom_range(99) < 8) begin
            s_tvalid <= 0;
            @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tdata  <= d;
        do @(posedge i_clk); while (!s_tready);
        sb.note_tick(d, kp_shadow, kv_shadow, grav_shadow);
    endtask

    function automatic bit [143:0] pack_tick(int a[3], int tg[3], int sp[3]);
        bit [143:0] d;
        d = '0;
        for (int j = 0; j < 3; j++) begin
            d[15*j +: 15]      = a[j][14:0];
            d[45 + 15*j +: 15] = tg[j][14:0];
            d[90 + 16*j +: 16] = sp[j][15:0];
        end
        return d;
    endfunction

    function automatic int rand_angle();
        case ($urandom_range(9))
            0: return $urandom_range(32767) - 16384;      // any 15-bit pattern
            1: return ($urandom_range(1) ? 12868 : -12868);
            default: return $urandom_range(25736) - 12868;
        endcase
    endfunction

    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 0;
        while (sb.exp_torque_q.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (pdgc_pkg::NUM_STG + 4) @(posedge i_clk);
    endtask

    task automatic run_random(int n);
        int a[3], tg[3], sp[3];
        for (int k = 0; k < n; k++) begin
            if (k == n / 3) calm = 1;
            if (k == n / 2) calm = 0;
            for (int j = 0; j < 3; j++) begin
                a[j]  = rand_angle();
                tg[j] = rand_angle();
                sp[j] = $urandom_range(65535) - 32768;
            end
            send_tick(pack_tick(a, tg, sp));
        end
    endtask

    initial begin
        int a[3], tg[3], sp[3];
        bit [143:0] d;
        calm = 0;
        timed_out = 0;
        grav_shadow = 1;
        i_rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        i_cfg_valid = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: reset gains (gravity only), field extremes, out-of-range angles
        for (int k = 0; k < 8; k++) begin
            for (int j = 0; j < 3; j++) begin
                a[j]  = (k[0] ? 12868 : -12868) >>> (k / 2);
                tg[j] = -a[j];
                sp[j] = k[0] ? 32767 : -32768;
            end
            send_tick(pack_tick(a, tg, sp));
        end
        d = {144{1'b1}};
        send_tick(d);
        d = 144'h0000_4000_2000_8000_7FFF_4000_3FFF_4000_3FFF;
        send_tick(d);
        send_tick('0);
        drain();

        // Saturation with maximum gains and gravity on
        set_gains(16'hFFFF, 16'hFFFF, 1);
        for (int k = 0; k < 6; k++) begin
            for (int j = 0; j < 3; j++) begin
                a[j]  = k[0] ? -12868 : 12868;
                tg[j] = -a[j];
                sp[j] = k[1] ? -32768 : 32767;
            end
            send_tick(pack_tick(a, tg, sp));
        end
        send_tick({144{1'b1}});
        drain();

        // Random phases across gain settings, gravity on and off, float mode
        set_gains(16'h0100, 16'h0080, 1);
        run_random(250);
        drain();
        set_gains(16'h0000, 16'h0000, 1);  // float mode
        run_random(120);
        drain();
        set_gains(16'h3A5C, 16'h0000, 0);  // goto without damping, no gravity
        run_random(150);
        drain();
        set_gains(16'($urandom), 16'($urandom), 1'($urandom_range(1)));
        run_random(200);
        drain();
        set_gains(16'hFFFF, 16'hFFFF, 0);
        run_random(200);
        drain();

        if (sb.exp_torque_q.size() == 0 && sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
